>>> design/pi_controller_permille_clamped_macros.svh
// Assertion helpers for the PI controller; clk and rst_n are taken from the using module.
`ifndef PI_CONTROLLER_PERMILLE_CLAMPED_MACROS_SVH
`define PI_CONTROLLER_PERMILLE_CLAMPED_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define PCPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent
`define PCPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pcpc_pkg.sv
package pcpc_pkg;

  // 16-bit signed sample, gain and limit word
  typedef logic signed [15:0] word_t;

  // Configuration register indexes
  localparam logic [1:0] REG_KP    = 2'd0;
  localparam logic [1:0] REG_KI    = 2'd1;
  localparam logic [1:0] REG_UPPER = 2'd2;
  localparam logic [1:0] REG_LOWER = 2'd3;

  // Reset values of the limits
  localparam word_t UPPER_RESET = 16'sh7FFF;
  localparam word_t LOWER_RESET = 16'sh8000;

  // Divide by 1000: drop three bits, then multiply by ceil(2^35 / 125) and keep bits 35 up.
  // Exact for magnitudes up to 2^30 (worst-case error term 7 * 2^27 < 2^35).
  localparam int          PRE_SHIFT   = 3;
  localparam int          RECIP_SHIFT = 35;
  localparam logic [28:0] RECIP_M     = 29'd274877907;

  // Clamp to the limits, upper test first
  function automatic word_t clamp_lim(input word_t v, input word_t upper, input word_t lower);
    word_t r;
    if (v > upper) begin
      r = upper;
    end else if (v < lower) begin
      r = lower;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> design/pi_controller_permille_clamped.sv
// PI controller with a clamped integrator, gains in thousandths.
// Input channel: in_valid/in_ready transfer one signed error sample (in_error).
// Output channel: out_valid/out_ready transfer one drive word (out_drive) per sample.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 kp, 1 ki,
// 2 upper limit, 3 lower limit) in the same cycle; write only while idle.
// Pipeline: an input transfer reaches out_valid through six registers
// (input, gain products, magnitudes, reciprocal multiply, sign restore,
// integrator/result).
// Throughput: one sample per cycle while out_ready is high; the integrator add and
// clamp are combinational in the last stage, which sets the rate. Each stage holds its
// item when the next stage is full, so a stalled receiver fills the pipeline before in_ready drops.
// Reset (synchronous, active low): integrator to 0, gains to 0, limits to
// +32767/-32768, all stages empty.
// Inverted limits (upper below lower) give a drive of 0 while the integrator is
// still clamped with the upper test first.
module pi_controller_permille_clamped (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pcpc_pkg::word_t   in_error,
  output logic              out_valid,
  input  logic              out_ready,
  output pcpc_pkg::word_t   out_drive,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_wdata
);

  // Configuration registers
  pcpc_pkg::word_t kp_r, ki_r, upper_r, lower_r;

  // Pipeline valid bits and per-stage readiness
  logic a_vld_r, b_vld_r, c_vld_r, d_vld_r, e_vld_r, out_valid_r;
  logic a_rdy, b_rdy, c_rdy, d_rdy, e_rdy, f_rdy;

  // Stage payloads
  pcpc_pkg::word_t     err_a_r;
  logic signed [31:0]  prod_i_b_r, prod_p_b_r;
  logic signed [31:0]  prod_i_nxt, prod_p_nxt;
  logic [27:0]         mag_i_c_r, mag_p_c_r;
  logic [31:0]         abs_i, abs_p;
  logic                sgn_i_c_r, sgn_p_c_r;
  logic [56:0]         recip_i, recip_p;
  logic [15:0]         q_i_d_r, q_p_d_r;
  logic                sgn_i_d_r, sgn_p_d_r;
  logic [15:0]         q_i_nxt, q_p_nxt;
  pcpc_pkg::word_t     q_i_e_r, q_p_e_r;
  pcpc_pkg::word_t     integ_r, integ_nxt, integ_sum, drive_sum, drive_cl, drive_nxt;
  pcpc_pkg::word_t     drive_r;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r    <= '0;
      ki_r    <= '0;
      upper_r <= pcpc_pkg::UPPER_RESET;
      lower_r <= pcpc_pkg::LOWER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pcpc_pkg::REG_KP:    kp_r    <= cfg_wdata;
        pcpc_pkg::REG_KI:    ki_r    <= cfg_wdata;
        pcpc_pkg::REG_UPPER: upper_r <= cfg_wdata;
        pcpc_pkg::REG_LOWER: lower_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // A stage takes a new item when it is empty or its item moves on
  assign f_rdy    = !out_valid_r || out_ready;
  assign e_rdy    = !e_vld_r || f_rdy;
  assign d_rdy    = !d_vld_r || e_rdy;
  assign c_rdy    = !c_vld_r || d_rdy;
  assign b_rdy    = !b_vld_r || c_rdy;
  assign a_rdy    = !a_vld_r || b_rdy;
  assign in_ready = a_rdy;

  // Datapath between stages
  always_comb begin
    prod_i_nxt = 32'(err_a_r) * 32'(ki_r);
    prod_p_nxt = 32'(err_a_r) * 32'(kp_r);
    abs_i      = prod_i_b_r[31] ? (32'd0 - 32'(prod_i_b_r)) : 32'(prod_i_b_r);
    abs_p      = prod_p_b_r[31] ? (32'd0 - 32'(prod_p_b_r)) : 32'(prod_p_b_r);
    recip_i    = 57'(mag_i_c_r) * 57'(pcpc_pkg::RECIP_M);
    recip_p    = 57'(mag_p_c_r) * 57'(pcpc_pkg::RECIP_M);
    q_i_nxt    = sgn_i_d_r ? (16'd0 - q_i_d_r) : q_i_d_r;
    q_p_nxt    = sgn_p_d_r ? (16'd0 - q_p_d_r) : q_p_d_r;
    integ_sum  = integ_r + q_i_e_r;
    integ_nxt  = pcpc_pkg::clamp_lim(integ_sum, upper_r, lower_r);
    drive_sum  = integ_nxt + q_p_e_r;
    drive_cl   = pcpc_pkg::clamp_lim(drive_sum, upper_r, lower_r);
    drive_nxt  = (upper_r < lower_r) ? '0 : drive_cl;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      d_vld_r     <= 1'b0;
      e_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_rdy) a_vld_r     <= in_valid;
      if (b_rdy) b_vld_r     <= a_vld_r;
      if (c_rdy) c_vld_r     <= b_vld_r;
      if (d_rdy) d_vld_r     <= c_vld_r;
      if (e_rdy) e_vld_r     <= d_vld_r;
      if (f_rdy) out_valid_r <= e_vld_r;
    end
  end

  // Advance payloads; hold them while the next stage is full
  always_ff @(posedge clk) begin
    if (in_valid && a_rdy) begin
      err_a_r <= in_error;
    end
    if (a_vld_r && b_rdy) begin
      prod_i_b_r <= prod_i_nxt;
      prod_p_b_r <= prod_p_nxt;
    end
    if (b_vld_r && c_rdy) begin
      mag_i_c_r <= abs_i[30:pcpc_pkg::PRE_SHIFT];
      mag_p_c_r <= abs_p[30:pcpc_pkg::PRE_SHIFT];
      sgn_i_c_r <= prod_i_b_r[31];
      sgn_p_c_r <= prod_p_b_r[31];
    end
    if (c_vld_r && d_rdy) begin
      q_i_d_r   <= recip_i[pcpc_pkg::RECIP_SHIFT +: 16];
      q_p_d_r   <= recip_p[pcpc_pkg::RECIP_SHIFT +: 16];
      sgn_i_d_r <= sgn_i_c_r;
      sgn_p_d_r <= sgn_p_c_r;
    end
    if (d_vld_r && e_rdy) begin
      q_i_e_r <= q_i_nxt;
      q_p_e_r <= q_p_nxt;
    end
    if (e_vld_r && f_rdy) begin
      drive_r <= drive_nxt;
    end
  end

  // Update the integrator once per item reaching the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (e_vld_r && f_rdy) begin
      integ_r <= integ_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = drive_r;

`include "pi_controller_permille_clamped_macros.svh"

  `PCPC_ASSERT_NOW(a_inverted_zero, out_valid_r && (upper_r < lower_r), out_drive == '0, "drive not zero with inverted limits")
  `PCPC_ASSERT_NOW(a_drive_in_range, out_valid_r && !(upper_r < lower_r), (out_drive <= upper_r) && (out_drive >= lower_r), "drive outside limits")
  `PCPC_ASSERT_NEXT(a_integ_hold, !(e_vld_r && f_rdy), $stable(integ_r), "integrator moved without an item")
  `PCPC_ASSERT_NOW(a_ready_flow, out_ready, in_ready, "input stalled while output drains")

endmodule

>>> sim/testbench.sv
module testbench;
  import pcpc_pkg::*;

  localparam int GAIN_DIV       = 1000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_AFTER     = 80;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PRINT_LIMIT    = 100;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  word_t       in_error  = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  word_t       out_drive;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = REG_KP;
  logic [15:0] cfg_wdata = '0;

  // Controller state as the testbench sees it
  int kp_gain   = 0;
  int ki_gain   = 0;
  int upper_lim = 32767;
  int lower_lim = -32768;
  int integ_acc = 0;

  word_t error_pending_q[$];
  word_t drive_expected_q[$];

  int fail_count   = 0;
  int in_count     = 0;
  int stall_cycles = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  bit idle_on      = 1'b1;

  pi_controller_permille_clamped u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_error  (in_error),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_drive (out_drive),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Keep the low 16 bits, sign-extended
  function automatic int wrap16(input int v);
    int w;
    w = {{16{v[15]}}, v[15:0]};
    return w;
  endfunction

  // Upper test first, so inverted limits still resolve
  function automatic int fit_limits(input int v);
    int r;
    if (v > upper_lim) begin
      r = upper_lim;
    end else if (v < lower_lim) begin
      r = lower_lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Advance the integrator by one sample and queue the drive it gives
  task automatic predict_drive(input word_t err_w);
    int err;
    int drv;
    err = err_w;
    integ_acc = fit_limits(wrap16(integ_acc + wrap16((err * ki_gain) / GAIN_DIV)));
    drv = fit_limits(wrap16(integ_acc + (err * kp_gain) / GAIN_DIV));
    if (upper_lim < lower_lim) begin
      drv = 0;
    end
    drive_expected_q.push_back(word_t'(drv));
  endtask

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    if (fail_count < PRINT_LIMIT) begin
      $display("ERROR %s: drive %0d, expected %0d", what, got, want);
    end
    fail_count++;
  endtask

  function automatic int rnd16();
    int v;
    v = int'($urandom_range(0, 65535)) - 32768;
    return v;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    int g;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      g = 0;
    end else if (r < 90) begin
      g = $urandom_range(1, 3);
    end else if (r < 97) begin
      g = $urandom_range(4, 12);
    end else begin
      g = $urandom_range(20, 60);
    end
    return g;
  endfunction

  function automatic int pick_gain();
    int r;
    int g;
    r = $urandom_range(0, 9);
    case (r)
      0: g = -32768;
      1: g = 32767;
      2: g = 0;
      3, 4: g = int'($urandom_range(0, 4000)) - 2000;
      default: g = rnd16();
    endcase
    return g;
  endfunction

  function automatic word_t pick_error();
    int r;
    word_t e;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      e = 16'sh7FFF;
    end else if (r == 1) begin
      e = 16'sh8000;
    end else if (r < 8) begin
      e = word_t'(int'($urandom_range(0, 100)) - 50);
    end else begin
      e = word_t'($urandom_range(0, 65535));
    end
    return e;
  endfunction

  task automatic pick_limits(output int up, output int lo);
    int r;
    int a;
    int b;
    r = $urandom_range(0, 9);
    a = rnd16();
    b = rnd16();
    case (r)
      0: begin
        up = 32767;
        lo = -32768;
      end
      1: begin
        up = int'($urandom_range(0, 2000)) - 3000;
        lo = $urandom_range(1000, 3000);
      end
      2: begin
        up = a;
        lo = a;
      end
      3, 4: begin
        up = $urandom_range(1, 3000);
        lo = -int'($urandom_range(1, 3000));
      end
      default: begin
        up = (a > b) ? a : b;
        lo = (a > b) ? b : a;
      end
    endcase
  endtask

  // One register write; the model takes the value at once
  task automatic write_reg(input logic [1:0] idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[15:0];
    case (idx)
      REG_KP:    kp_gain   = wrap16(val);
      REG_KI:    ki_gain   = wrap16(val);
      REG_UPPER: upper_lim = wrap16(val);
      REG_LOWER: lower_lim = wrap16(val);
      default: ;
    endcase
  endtask

  task automatic configure(input int kp, input int ki, input int up, input int lo);
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_UPPER, up);
    write_reg(REG_LOWER, lo);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait for every transfer to complete, then let the pipeline go quiet
  task automatic settle();
    while (error_pending_q.size() != 0 || drive_expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sender: present the head of the pending queue, hold it until the transfer; random gaps and drain waits come between
  always @(posedge clk) begin : driver
    bit took;
    int valid_gap;
    bit drain_wait;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      valid_gap  = 0;
      drain_wait = 1'b0;
    end else begin
      took = in_valid && in_ready;
      if (took) begin
        predict_drive(in_error);
        void'(error_pending_q.pop_front());
        in_count <= in_count + 1;
        if ($urandom_range(0, 149) == 0) begin
          drain_wait = 1'b1;
        end
      end
      if (drain_wait && drive_expected_q.size() == 0) begin
        drain_wait = 1'b0;
      end
      if (in_valid && !took) begin
        // hold the current item
      end else if (valid_gap != 0) begin
        valid_gap--;
        in_valid <= 1'b0;
      end else if (error_pending_q.size() != 0 && !drain_wait) begin
        in_valid  <= 1'b1;
        in_error  <= error_pending_q[0];
        valid_gap = idle_on ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off once the run is under way
  always @(posedge clk) begin
    if (!hold_done && in_count >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: check each transfer against the oldest expected drive
  always @(posedge clk) begin : monitor
    int ready_gap;
    word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (drive_expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_drive, '0);
        end else begin
          want = drive_expected_q.pop_front();
          if (out_drive !== want) begin
            report_mismatch("wrong drive", out_drive, want);
          end
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (ready_gap != 0) begin
        ready_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        ready_gap = idle_on ? pick_gap() : 0;
      end
    end
  end

  // Give up when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("pi_controller_permille_clamped: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int kp;
    int ki;
    int up;
    int lo;
    int n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Full-scale gains with open limits: scaled terms overflow 16 bits and wrap
    configure(32767, 32767, 32767, -32768);
    error_pending_q.push_back(16'sh7FFF);
    error_pending_q.push_back(16'sh8000);
    error_pending_q.push_back(16'sh0001);
    error_pending_q.push_back(16'shFFFF);
    error_pending_q.push_back(16'sh0000);
    error_pending_q.push_back(16'sh7FFF);
    settle();

    // Most negative gains, narrow window: truncation near the 1000 boundary
    configure(-32768, -32768, 100, -100);
    error_pending_q.push_back(16'sh8000);
    error_pending_q.push_back(16'sh7FFF);
    error_pending_q.push_back(16'sd999);
    error_pending_q.push_back(-16'sd999);
    error_pending_q.push_back(16'sd1000);
    error_pending_q.push_back(-16'sd1001);
    settle();

    // Inverted limits: drive is zero, integrator still clamped
    configure(1000, 1000, -50, 50);
    error_pending_q.push_back(16'sd10);
    error_pending_q.push_back(-16'sd10);
    error_pending_q.push_back(16'sd100);
    error_pending_q.push_back(-16'sd100);
    error_pending_q.push_back(16'sd0);
    settle();

    // Equal limits pin everything to one value
    configure(0, 1, 7, 7);
    error_pending_q.push_back(16'sd5);
    error_pending_q.push_back(-16'sd5);
    settle();

    // Random phases, each under its own setting
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          kp = 1500;
          ki = 200;
          up = 32767;
          lo = -32768;
        end
        1: begin
          kp = -32768;
          ki = 32767;
          up = 2000;
          lo = -2000;
        end
        2: begin
          kp = pick_gain();
          ki = pick_gain();
          up = -500;
          lo = 500;
        end
        default: begin
          kp = pick_gain();
          ki = pick_gain();
          pick_limits(up, lo);
        end
      endcase
      configure(kp, ki, up, lo);
      idle_on = (p != 3);
      n = (p == 0) ? 200 : 100;
      for (int i = 0; i < n; i++) begin
        error_pending_q.push_back(pick_error());
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("pi_controller_permille_clamped: match");
    end else begin
      $display("pi_controller_permille_clamped: mismatch");
    end
    $finish;
  end

endmodule
